// ----- rtl/mafr_pkg.sv -----
package mafr_pkg;

    localparam int WINDOW     = 16;
    localparam int ADDR_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W     = $clog2(WINDOW + 1);
    localparam int TS_W       = 32;
    localparam int IVL_W      = 16;
    localparam int TPS_W      = 16;
    localparam int FRAC_W     = 8;
    localparam int SUM_W      = IVL_W + $clog2(WINDOW);
    localparam int PROD_W     = TPS_W + FILL_W;
    localparam int NUM_W      = PROD_W + FRAC_W;
    localparam int RATE_W     = 24;
    localparam int DIV_CNT_W  = $clog2(NUM_W + 1);

    localparam logic [TPS_W-1:0]  TPS_RESET = TPS_W'(1000);
    localparam logic [IVL_W-1:0]  IVL_MAX   = '1;
    localparam logic [RATE_W-1:0] RATE_MAX  = '1;

endpackage

// ----- rtl/mafr_if.sv -----
interface mafr_frame_if;
    import mafr_pkg::*;

    logic            valid;
    logic            ready;
    logic [TS_W-1:0] timestamp;

    modport source (output valid, output timestamp, input ready);
    modport sink (input valid, input timestamp, output ready);
endinterface

interface mafr_rate_if;
    import mafr_pkg::*;

    logic              valid;
    logic              ready;
    logic [RATE_W-1:0] rate_q8;
    logic              no_interval;

    modport source (output valid, output rate_q8, output no_interval, input ready);
    modport sink (input valid, input rate_q8, input no_interval, output ready);
endinterface

// ----- rtl/mafr_ram.sv -----
module mafr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- rtl/mafr_div.sv -----
module mafr_div
    import mafr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [SUM_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    logic [SUM_W-1:0]     r_rem;
    logic [NUM_W-1:0]     r_quot;
    logic [SUM_W-1:0]     r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [SUM_W:0]       trial;
    logic [SUM_W:0]       diff;

    assign trial = {r_rem, r_quot[NUM_W-1]};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_num;
            r_den  <= i_den;
        end else if (r_busy) begin
            if (!diff[SUM_W]) begin
                r_rem  <= diff[SUM_W-1:0];
                r_quot <= {r_quot[NUM_W-2:0], 1'b1};
            end else begin
                r_rem  <= trial[SUM_W-1:0];
                r_quot <= {r_quot[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- rtl/moving_average_frame_rate_meter.sv -----
// Each frame transfer carries a free-running 32-bit tick timestamp; the block
// keeps the last 16 frame intervals (each clamped to 65535 ticks) in a small
// RAM ring with a running sum, and returns one result per frame: the average
// frame rate ticks_per_second * frames_in_window / interval_sum in unsigned
// Q16.8, saturated to all ones, or all ones with no_interval set when the sum
// is zero. The first frame after reset counts as a zero interval. The ring
// entry being replaced is read at the frame transfer. A frame with a nonzero
// interval sum then goes through these steps before its result is offered:
// the ring and sum are updated and the divider is started, the bit-serial
// divider runs its 29 steps, the divider's finish is seen, and the output
// register is loaded. A zero interval sum skips the divider. A new frame is
// accepted in the cycle after the result is loaded into the output register;
// a result that waits in the output register for the sink holds the next
// result in S_DONE, and so holds off the frame after it, for as long as it
// waits. The ring needs no clearing after reset: until it is full, the entry
// being replaced reads as zero. Write ticks_per_second only while no frame is
// in progress.
module moving_average_frame_rate_meter
    import mafr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [TPS_W-1:0]  i_cfg_wdata,
    mafr_frame_if.sink        i_frame,
    mafr_rate_if.source       o_rate
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [TPS_W-1:0]  r_tps;
    logic [ADDR_W-1:0] r_wpos;
    logic [FILL_W-1:0] r_fill;
    logic [SUM_W-1:0]  r_sum;
    logic [TS_W-1:0]   r_prev;
    logic              r_started;
    logic [IVL_W-1:0]  r_delta;
    logic              r_zero;
    logic              r_out_valid;
    logic [RATE_W-1:0] r_out_rate;
    logic              r_out_flag;

    logic              accept;
    logic [TS_W-1:0]   ts_diff;
    logic [IVL_W-1:0]  delta;
    logic [IVL_W-1:0]  ram_rdata;
    logic [IVL_W-1:0]  old_ivl;
    logic              ring_full;
    logic [SUM_W-1:0]  sum_next;
    logic [FILL_W-1:0] fill_next;
    logic [ADDR_W-1:0] wpos_next;
    logic [PROD_W-1:0] prod;
    logic [NUM_W-1:0]  num;
    logic              div_start;
    logic              div_done;
    logic [NUM_W-1:0]  div_quot;
    logic [RATE_W-1:0] rate_sat;
    logic              out_free;

    assign out_free       = !r_out_valid || o_rate.ready;
    assign i_frame.ready  = (r_state == S_IDLE);
    assign accept         = i_frame.valid && i_frame.ready;

    assign ts_diff = i_frame.timestamp - r_prev;
    assign delta   = !r_started ? '0 :
                     (|ts_diff[TS_W-1:IVL_W]) ? IVL_MAX : ts_diff[IVL_W-1:0];

    assign ring_full = (r_fill == FILL_W'(WINDOW));
    assign old_ivl   = ring_full ? ram_rdata : '0;
    assign sum_next  = r_sum - SUM_W'(old_ivl) + SUM_W'(r_delta);
    assign fill_next = ring_full ? r_fill : r_fill + 1'b1;
    assign wpos_next = (r_wpos == ADDR_W'(WINDOW - 1)) ? '0 : r_wpos + 1'b1;
    assign prod      = PROD_W'(r_tps) * PROD_W'(fill_next);
    assign num       = {prod, {FRAC_W{1'b0}}};
    assign div_start = (r_state == S_READ) && (sum_next != '0);

    assign rate_sat = (|div_quot[NUM_W-1:RATE_W]) ? RATE_MAX : div_quot[RATE_W-1:0];

    mafr_ram #(
        .WIDTH (IVL_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (r_state == S_READ),
        .i_waddr (r_wpos),
        .i_wdata (r_delta),
        .i_raddr (r_wpos),
        .o_rdata (ram_rdata)
    );

    mafr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num),
        .i_den   (sum_next),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = (sum_next == '0) ? S_DONE : S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tps       <= TPS_RESET;
            r_wpos      <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_prev      <= '0;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_tps <= i_cfg_wdata;
            end
            if (accept) begin
                r_prev    <= i_frame.timestamp;
                r_started <= 1'b1;
            end
            if (r_state == S_READ) begin
                r_sum  <= sum_next;
                r_fill <= fill_next;
                r_wpos <= wpos_next;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rate.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_delta <= delta;
        end
        if (r_state == S_READ) begin
            r_zero <= (sum_next == '0);
        end
        if (r_state == S_DONE && out_free) begin
            r_out_rate <= r_zero ? RATE_MAX : rate_sat;
            r_out_flag <= r_zero;
        end
    end

    assign o_rate.valid       = r_out_valid;
    assign o_rate.rate_q8     = r_out_rate;
    assign o_rate.no_interval = r_out_flag;

endmodule

// ----- verif/moving_average_frame_rate_meter_tb.sv -----
module moving_average_frame_rate_meter_tb
    import mafr_pkg::*;
();

    localparam int LATENCY_CYCLES = 40;
    localparam int DRAIN_LIMIT    = 200000;
    localparam int LONG_HOLD      = 600;
    localparam int MAX_PRINTED    = 100;

    typedef struct packed {
        logic [RATE_W-1:0] rate_q8;
        logic              no_interval;
    } t_rate_result;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [TPS_W-1:0] i_cfg_wdata;

    mafr_frame_if frame_if ();
    mafr_rate_if  rate_if ();

    moving_average_frame_rate_meter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_frame     (frame_if),
        .o_rate      (rate_if)
    );

    logic [TS_W-1:0] frame_stamps [$];
    t_rate_result    rate_expect [$];
    int              mismatch_count;
    int              tx_idle_pct;
    int              rx_stall_pct;
    int              rx_hold_cycles;
    logic [TS_W-1:0] gen_stamp;

    logic [IVL_W-1:0]  ivl_ring [WINDOW];
    logic [ADDR_W-1:0] ring_pos;
    logic [FILL_W-1:0] frames_held;
    logic [SUM_W-1:0]  ivl_sum;
    logic [TS_W-1:0]   last_stamp;
    bit                seen_frame;
    logic [TPS_W-1:0]  tps_setting;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("moving_average_frame_rate_meter_tb NOT OK");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED) begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    // Updates the interval window with one frame and queues the rate it yields.
    task automatic predict_frame_rate(input logic [TS_W-1:0] stamp);
        logic [TS_W-1:0] gap;
        logic [63:0]     quotient;
        t_rate_result    res;
        gap = seen_frame ? stamp - last_stamp : '0;
        seen_frame = 1'b1;
        last_stamp = stamp;
        if (gap > IVL_MAX) begin
            gap = TS_W'(IVL_MAX);
        end
        ivl_sum = ivl_sum - ivl_ring[ring_pos] + gap[IVL_W-1:0];
        ivl_ring[ring_pos] = gap[IVL_W-1:0];
        ring_pos = ring_pos + 1'b1;
        if (frames_held < WINDOW) begin
            frames_held = frames_held + 1'b1;
        end
        if (ivl_sum == 0) begin
            res.rate_q8 = RATE_MAX;
            res.no_interval = 1'b1;
        end else begin
            quotient = (64'(tps_setting) * 64'(frames_held)) << FRAC_W;
            quotient = quotient / 64'(ivl_sum);
            res.rate_q8 = (quotient > 64'(RATE_MAX)) ? RATE_MAX : quotient[RATE_W-1:0];
            res.no_interval = 1'b0;
        end
        rate_expect.push_back(res);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_if.valid <= 1'b0;
        end else if (!frame_if.valid || frame_if.ready) begin
            if (frame_stamps.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                frame_if.valid <= 1'b1;
                frame_if.timestamp <= frame_stamps.pop_front();
            end else begin
                frame_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rate_if.ready <= 1'b0;
        end else if (rx_hold_cycles > 0) begin
            rx_hold_cycles <= rx_hold_cycles - 1;
            rate_if.ready <= 1'b0;
        end else begin
            rate_if.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_rate_result want;
        if (i_rst_n) begin
            if (rate_if.valid && rate_if.ready) begin
                if (rate_expect.size() == 0) begin
                    report_mismatch($sformatf("unexpected result rate_q8=%h no_interval=%b",
                                              rate_if.rate_q8, rate_if.no_interval));
                end else begin
                    want = rate_expect.pop_front();
                    if (rate_if.rate_q8 !== want.rate_q8) begin
                        report_mismatch($sformatf("rate_q8 got %h want %h",
                                                  rate_if.rate_q8, want.rate_q8));
                    end
                    if (rate_if.no_interval !== want.no_interval) begin
                        report_mismatch($sformatf("no_interval got %b want %b",
                                                  rate_if.no_interval, want.no_interval));
                    end
                end
            end
            if (frame_if.valid && frame_if.ready) begin
                predict_frame_rate(frame_if.timestamp);
            end
        end
    end

    task automatic wait_for_results();
        int waited;
        waited = 0;
        while ((frame_stamps.size() != 0 || frame_if.valid || rate_expect.size() != 0)
               && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        if (waited >= DRAIN_LIMIT) begin
            report_mismatch($sformatf("%0d results still outstanding", rate_expect.size()));
        end
        repeat (LATENCY_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_tps(input logic [TPS_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tps_setting = value;
        @(negedge i_clk);
    endtask

    task automatic queue_frame(input logic [TS_W-1:0] stamp);
        frame_stamps.push_back(stamp);
        gen_stamp = stamp;
    endtask

    // Mostly short frame intervals, with clamped gaps, repeated stamps,
    // runs long enough to empty the window sum, and unrelated stamps.
    task automatic queue_random_frames(input int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 2) begin
                repeat (WINDOW + 1) queue_frame(gen_stamp);
                n += WINDOW;
            end else if (pick < 50) begin
                queue_frame(gen_stamp + $urandom_range(40));
            end else if (pick < 75) begin
                queue_frame(gen_stamp + $urandom_range(65535));
            end else if (pick < 85) begin
                queue_frame(gen_stamp + $urandom_range(32'hFFFF_FFFF, 32'h0001_0000));
            end else if (pick < 92) begin
                queue_frame(gen_stamp);
            end else begin
                queue_frame($urandom);
            end
        end
    endtask

    task automatic run_random_phase(input logic [TPS_W-1:0] tps, input int idle_pct,
                                    input int stall_pct, input int count);
        wait_for_results();
        write_tps(tps);
        tx_idle_pct = idle_pct;
        rx_stall_pct = stall_pct;
        queue_random_frames(count);
        wait_for_results();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        frame_if.valid = 1'b0;
        frame_if.timestamp = '0;
        rate_if.ready = 1'b0;
        mismatch_count = 0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        rx_hold_cycles = 0;
        gen_stamp = '0;
        for (int k = 0; k < WINDOW; k++) begin
            ivl_ring[k] = '0;
        end
        ring_pos = '0;
        frames_held = '0;
        ivl_sum = '0;
        last_stamp = '0;
        seen_frame = 1'b0;
        tps_setting = TPS_RESET;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        queue_frame(32'h0000_0000);
        queue_frame(32'h0000_0000);
        queue_frame(32'h0000_0001);
        queue_frame(32'h0001_0001);
        queue_frame(32'h0002_0000);
        queue_frame(32'hFFFF_FFFF);
        queue_frame(32'h0000_0002);
        wait_for_results();

        write_tps(16'hFFFF);
        repeat (WINDOW) queue_frame(gen_stamp);
        queue_frame(gen_stamp + 1);
        wait_for_results();

        write_tps(16'h0000);
        queue_frame(gen_stamp + 5);
        wait_for_results();

        run_random_phase(16'd1, 0, 0, 300);
        run_random_phase(16'hFFFF, 79, 0, 300);
        run_random_phase(16'($urandom_range(65535, 1)), 0, 79, 300);
        run_random_phase(16'($urandom_range(65535, 1)), 16, 16, 300);

        write_tps(TPS_RESET);
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        rx_hold_cycles = LONG_HOLD;
        queue_random_frames(40);
        wait_for_results();
        queue_random_frames(260);
        wait_for_results();

        run_random_phase(16'($urandom_range(65535, 1)), 0, 0, 300);

        if (mismatch_count == 0) begin
            $display("moving_average_frame_rate_meter_tb OK");
        end else begin
            $display("moving_average_frame_rate_meter_tb NOT OK");
        end
        $finish;
    end

endmodule
